### src/pcp_pkg.sv
// Shared constants, widths and types for the power center of three points block.
// Depends on nothing; every other file of the block imports it.

package pcp_pkg;

	// Number format of coordinates and weights
	localparam int CW = 32;                 // coordinate width
	localparam int FB = 16;                 // fraction bits

	// Difference and first product widths
	localparam int DW  = CW + 1;            // signed difference
	localparam int AW  = CW + 1;            // magnitude of a difference
	localparam int HW  = (AW + 1) / 2;      // low slice of a split operand
	localparam int PPW = 2 * HW;            // partial product
	localparam int PW  = 2 * AW;            // full product magnitude
	localparam int DNW = PW + 2;            // signed denominator D

	// Squared length plus weight term
	localparam int NW  = ((PW + 1 > DW + FB) ? PW + 1 : DW + FB) + 1;
	localparam int NC  = (NW + HW - 1) / HW; // slices of |N|
	localparam int CKW = HW + AW;           // one slice times a difference
	localparam int MW  = NW + AW;           // |N| times a difference
	localparam int XW  = MW + 1;            // signed numerator

	// Divider
	localparam int QB  = CW + 2;            // quotient bits kept below the overflow bit
	localparam int AAW = XW + 1;            // dividend |num| + |D|
	localparam int BW  = DNW + 1;           // divisor 2*|D|
	localparam int RW  = ((AAW > BW + QB) ? AAW : BW + QB) + 1;

	// Final add and clip
	localparam int VW = QB + 3;
	localparam logic signed [VW-1:0] VHI = VW'((64'sd1 <<< (CW - 1)) - 64'sd1);
	localparam logic signed [VW-1:0] VLO = ~VHI;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t p1_x, p1_y, p1_w;
		coord_t p2_x, p2_y, p2_w;
		coord_t p3_x, p3_y, p3_w;
	} pts_t;

	// Edge vectors from point one, as magnitude and sign, plus the base point
	typedef struct packed {
		logic [AW-1:0] ax2, ay2, ax3, ay3;
		logic          nx2, ny2, nx3, ny3;
		coord_t        bx, by;
	} dxy_t;

	// Side data that rides along with the numerator datapath
	typedef struct packed {
		logic [DNW-1:0] d_abs;
		logic           d_neg;
		logic           deg;
		coord_t         bx, by;
	} side_t;

	typedef struct packed {
		logic [XW-1:0] nx_abs;
		logic          nx_neg;
		logic [XW-1:0] ny_abs;
		logic          ny_neg;
		side_t         side;
	} front_t;

	// Travels through a divider next to the quotient
	typedef struct packed {
		logic   neg;
		logic   deg;
		coord_t base;
	} tag_t;

	typedef struct packed {
		coord_t center_x;
		coord_t center_y;
		logic   degenerate;
		logic   saturated;
	} res_t;

endpackage

### src/pcp_in_if.sv
// Input channel: three weighted points with a valid/ready handshake.
// Depends on pcp_pkg.

interface pcp_in_if import pcp_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t p1_x, p1_y, p1_w;
	coord_t p2_x, p2_y, p2_w;
	coord_t p3_x, p3_y, p3_w;

	modport source (
		output valid, p1_x, p1_y, p1_w, p2_x, p2_y, p2_w, p3_x, p3_y, p3_w,
		input  ready
	);
	modport sink (
		input  valid, p1_x, p1_y, p1_w, p2_x, p2_y, p2_w, p3_x, p3_y, p3_w,
		output ready
	);
endinterface

### src/pcp_out_if.sv
// Output channel: power center, degenerate and saturated flags with valid/ready.
// Depends on pcp_pkg.

interface pcp_out_if import pcp_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t center_x;
	coord_t center_y;
	logic   degenerate;
	logic   saturated;

	modport source (output valid, center_x, center_y, degenerate, saturated, input ready);
	modport sink (input valid, center_x, center_y, degenerate, saturated, output ready);
endinterface

### src/pcp_front.sv
// Front pipeline: edge vectors, D, N2/N3 and the two numerators, ten stages.
// Depends on pcp_pkg. Multiplies are split into half-width partial products.

module pcp_front import pcp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   in_valid,
	input  pts_t   pts,
	output logic   out_valid,
	output front_t out_data
);

	localparam int NPROD = 6;
	localparam int NPAIR = 4;

	function automatic logic [AW-1:0] mag_d(input logic signed [DW-1:0] v);
		mag_d = v[DW-1] ? AW'(-v) : AW'(v);
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;

	// Stage 1: differences from point one
	logic signed [DW-1:0] dx2, dy2, dx3, dy3, dw2, dw3;
	dxy_t g1;

	assign dx2 = DW'(pts.p2_x) - DW'(pts.p1_x);
	assign dy2 = DW'(pts.p2_y) - DW'(pts.p1_y);
	assign dw2 = DW'(pts.p2_w) - DW'(pts.p1_w);
	assign dx3 = DW'(pts.p3_x) - DW'(pts.p1_x);
	assign dy3 = DW'(pts.p3_y) - DW'(pts.p1_y);
	assign dw3 = DW'(pts.p3_w) - DW'(pts.p1_w);

	always_comb begin
		g1.ax2 = mag_d(dx2);
		g1.ay2 = mag_d(dy2);
		g1.ax3 = mag_d(dx3);
		g1.ay3 = mag_d(dy3);
		g1.nx2 = dx2[DW-1];
		g1.ny2 = dy2[DW-1];
		g1.nx3 = dx3[DW-1];
		g1.ny3 = dy3[DW-1];
		g1.bx  = pts.p1_x;
		g1.by  = pts.p1_y;
	end

	dxy_t                 g_s1, g_s2, g_s3, g_s4, g_s5;
	logic signed [DW-1:0] dw2_s1, dw3_s1, dw2_s2, dw3_s2, dw2_s3, dw3_s3;

	// Stage 2: partial products of each of the NPROD edge products
	logic [AW-1:0]  pa [NPROD];
	logic [AW-1:0]  pb [NPROD];
	logic [PPW-1:0] pp [NPROD][4];
	logic [PPW-1:0] pp_s2 [NPROD][4];

	always_comb begin
		pa[0] = g_s1.ax2; pb[0] = g_s1.ay3;
		pa[1] = g_s1.ax3; pb[1] = g_s1.ay2;
		pa[2] = g_s1.ax2; pb[2] = g_s1.ax2;
		pa[3] = g_s1.ay2; pb[3] = g_s1.ay2;
		pa[4] = g_s1.ax3; pb[4] = g_s1.ax3;
		pa[5] = g_s1.ay3; pb[5] = g_s1.ay3;
		for (int k = 0; k < NPROD; k++) begin
			pp[k][0] = PPW'(pa[k][HW-1:0]) * PPW'(pb[k][HW-1:0]);
			pp[k][1] = PPW'(pa[k][HW-1:0]) * PPW'(pb[k][AW-1:HW]);
			pp[k][2] = PPW'(pa[k][AW-1:HW]) * PPW'(pb[k][HW-1:0]);
			pp[k][3] = PPW'(pa[k][AW-1:HW]) * PPW'(pb[k][AW-1:HW]);
		end
	end

	// Stage 3: recombine partial products
	logic [PW-1:0] m [NPROD];
	logic [PW-1:0] m_s3 [NPROD];

	always_comb begin
		for (int k = 0; k < NPROD; k++) begin
			m[k] = (PW'(pp_s2[k][3]) << (2 * HW))
				+ ((PW'(pp_s2[k][1]) + PW'(pp_s2[k][2])) << HW)
				+ PW'(pp_s2[k][0]);
		end
	end

	// Stage 4: denominator and the two squared lengths with weight terms
	logic signed [DNW-1:0] e1, e2, d4;
	logic signed [NW-1:0]  n2, n3;
	logic signed [DNW-1:0] d_s4;
	logic signed [NW-1:0]  n2_s4, n3_s4;

	always_comb begin
		e1 = $signed(DNW'(m_s3[0]));
		e2 = $signed(DNW'(m_s3[1]));
		if (g_s3.nx2 ^ g_s3.ny3) e1 = -e1;
		if (g_s3.nx3 ^ g_s3.ny2) e2 = -e2;
		d4 = e1 - e2;
		n2 = $signed(NW'(m_s3[2])) + $signed(NW'(m_s3[3])) + (NW'(dw2_s3) <<< FB);
		n3 = $signed(NW'(m_s3[4])) + $signed(NW'(m_s3[5])) + (NW'(dw3_s3) <<< FB);
	end

	// Stage 5: magnitudes and the degenerate test
	logic [NW-1:0] na2_s5, na3_s5;
	logic          nn2_s5, nn3_s5;
	side_t         side5, side_s5, side_s6, side_s7, side_s8, side_s9;

	always_comb begin
		side5.d_abs = d_s4[DNW-1] ? DNW'(-d_s4) : DNW'(d_s4);
		side5.d_neg = d_s4[DNW-1];
		side5.deg   = (d_s4 == '0);
		side5.bx    = g_s4.bx;
		side5.by    = g_s4.by;
	end

	// Stage 6: sliced partial products of N times an edge component
	logic [NC*HW-1:0] nz [NPAIR];
	logic [AW-1:0]    fz [NPAIR];
	logic             sg [NPAIR];
	logic [PPW-1:0]   pq [NPAIR][NC][2];
	logic [PPW-1:0]   pq_s6 [NPAIR][NC][2];
	logic             sg_s6 [NPAIR];
	logic             sg_s7 [NPAIR];
	logic             sg_s8 [NPAIR];

	always_comb begin
		nz[0] = (NC*HW)'(na2_s5); fz[0] = g_s5.ay3; sg[0] = nn2_s5 ^ g_s5.ny3;
		nz[1] = (NC*HW)'(na3_s5); fz[1] = g_s5.ay2; sg[1] = nn3_s5 ^ g_s5.ny2;
		nz[2] = (NC*HW)'(na3_s5); fz[2] = g_s5.ax2; sg[2] = nn3_s5 ^ g_s5.nx2;
		nz[3] = (NC*HW)'(na2_s5); fz[3] = g_s5.ax3; sg[3] = nn2_s5 ^ g_s5.nx3;
		for (int k = 0; k < NPAIR; k++) begin
			for (int i = 0; i < NC; i++) begin
				pq[k][i][0] = PPW'(nz[k][i*HW +: HW]) * PPW'(fz[k][HW-1:0]);
				pq[k][i][1] = PPW'(nz[k][i*HW +: HW]) * PPW'(fz[k][AW-1:HW]);
			end
		end
	end

	// Stage 7: one row per slice
	logic [CKW-1:0] ck [NPAIR][NC];
	logic [CKW-1:0] ck_s7 [NPAIR][NC];

	always_comb begin
		for (int k = 0; k < NPAIR; k++) begin
			for (int i = 0; i < NC; i++) begin
				ck[k][i] = CKW'(pq_s6[k][i][0]) + (CKW'(pq_s6[k][i][1]) << HW);
			end
		end
	end

	// Stage 8: sum the slice rows
	logic [MW-1:0] pm [NPAIR];
	logic [MW-1:0] pm_s8 [NPAIR];

	always_comb begin
		for (int k = 0; k < NPAIR; k++) begin
			pm[k] = '0;
			for (int i = 0; i < NC; i++) begin
				pm[k] = pm[k] + (MW'(ck_s7[k][i]) << (i * HW));
			end
		end
	end

	// Stage 9: signed numerators
	logic signed [XW-1:0] f [NPAIR];
	logic signed [XW-1:0] nx9, ny9;
	logic signed [XW-1:0] nx_s9, ny_s9;

	always_comb begin
		for (int k = 0; k < NPAIR; k++) begin
			f[k] = $signed(XW'(pm_s8[k]));
			if (sg_s8[k]) f[k] = -f[k];
		end
		nx9 = f[0] - f[1];
		ny9 = f[2] - f[3];
	end

	// Stage 10: numerator magnitudes
	front_t f10, out_s10;

	always_comb begin
		f10.nx_abs = nx_s9[XW-1] ? XW'(-nx_s9) : XW'(nx_s9);
		f10.nx_neg = nx_s9[XW-1];
		f10.ny_abs = ny_s9[XW-1] ? XW'(-ny_s9) : XW'(ny_s9);
		f10.ny_neg = ny_s9[XW-1];
		f10.side   = side_s9;
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6  <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	// Data registers
	always_ff @(posedge clk) begin
		if (en) begin
			g_s1    <= g1;
			dw2_s1  <= dw2;
			dw3_s1  <= dw3;
			g_s2    <= g_s1;
			dw2_s2  <= dw2_s1;
			dw3_s2  <= dw3_s1;
			pp_s2   <= pp;
			g_s3    <= g_s2;
			dw2_s3  <= dw2_s2;
			dw3_s3  <= dw3_s2;
			m_s3    <= m;
			g_s4    <= g_s3;
			d_s4    <= d4;
			n2_s4   <= n2;
			n3_s4   <= n3;
			g_s5    <= g_s4;
			side_s5 <= side5;
			na2_s5  <= n2_s4[NW-1] ? NW'(-n2_s4) : NW'(n2_s4);
			nn2_s5  <= n2_s4[NW-1];
			na3_s5  <= n3_s4[NW-1] ? NW'(-n3_s4) : NW'(n3_s4);
			nn3_s5  <= n3_s4[NW-1];
			pq_s6   <= pq;
			sg_s6   <= sg;
			side_s6 <= side_s5;
			ck_s7   <= ck;
			sg_s7   <= sg_s6;
			side_s7 <= side_s6;
			pm_s8   <= pm;
			sg_s8   <= sg_s7;
			side_s8 <= side_s7;
			nx_s9   <= nx9;
			ny_s9   <= ny9;
			side_s9 <= side_s8;
			out_s10 <= f10;
		end
	end

	assign out_valid = v_s10;
	assign out_data  = out_s10;

endmodule

### src/pcp_div.sv
// Restoring divider, one quotient bit per stage, computing (|n|+|d|) / (2|d|).
// Depends on pcp_pkg. The top bit of the quotient marks an out-of-range result.

module pcp_div import pcp_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [XW-1:0]  num_abs,
	input  logic [DNW-1:0] den_abs,
	input  tag_t           tag_in,
	output logic           out_valid,
	output logic [QB:0]    quo,
	output tag_t           tag_out
);

	localparam int NST = QB + 2;

	logic          v_s   [NST];
	logic [RW-1:0] rem_s [NST];
	logic [QB:0]   q_s   [NST];
	logic [BW-1:0] b_s   [NST];
	tag_t          tag_s [NST];

	// Stage 0: dividend biased by |d| for round half away from zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= RW'(num_abs) + RW'(den_abs);
			q_s[0]   <= '0;
			b_s[0]   <= {den_abs, 1'b0};
			tag_s[0] <= tag_in;
		end
	end

	// One compare and subtract per stage, most significant bit first
	for (genvar i = 1; i < NST; i++) begin : g_step
		localparam int BIT = NST - 1 - i;
		logic [RW-1:0] sh;
		logic          ge;
		logic [QB:0]   qn;

		assign sh = RW'(b_s[i-1]) << BIT;
		assign ge = (rem_s[i-1] >= sh);

		// Quotient with this stage's bit filled in
		always_comb begin
			qn      = q_s[i-1];
			qn[BIT] = ge;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]      <= ge ? rem_s[i-1] - sh : rem_s[i-1];
				q_s[i]        <= qn;
				b_s[i]        <= b_s[i-1];
				tag_s[i]      <= tag_s[i-1];
			end
		end
	end

	assign out_valid = v_s[NST-1];
	assign quo       = q_s[NST-1];
	assign tag_out   = tag_s[NST-1];

endmodule

### src/power_center_of_three_points_unit.sv
// Power center of three weighted points: front pipeline, two dividers, final clip.
// Throughput: one item per cycle unless the skid register is occupied; the dividers resolve one bit per stage.
// A skid register at the output holds one result that was not taken; input is closed while it is occupied.
// Reset clears all valid bits and the skid valid flag; data registers, skid data included, are not reset.
// Depends on pcp_pkg, pcp_in_if, pcp_out_if, pcp_front and pcp_div.

module power_center_of_three_points_unit import pcp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	pcp_in_if.sink     pts,
	pcp_out_if.source  res
);

	logic   en;
	pts_t   pts_d;
	logic   f_valid;
	front_t f_data;
	tag_t   tag_x, tag_y, tq_x, tq_y;
	logic   vq_x, vq_y;
	logic [QB:0] q_x, q_y;

	// Whole pipeline advances unless the skid register is occupied
	logic skid_v_q;
	res_t skid_q;
	logic v_sout;
	res_t res_sout;

	assign en        = ~skid_v_q;
	assign pts.ready = en;

	assign pts_d = '{p1_x: pts.p1_x, p1_y: pts.p1_y, p1_w: pts.p1_w,
	                 p2_x: pts.p2_x, p2_y: pts.p2_y, p2_w: pts.p2_w,
	                 p3_x: pts.p3_x, p3_y: pts.p3_y, p3_w: pts.p3_w};

	pcp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (pts.valid),
		.pts      (pts_d),
		.out_valid(f_valid),
		.out_data (f_data)
	);

	// Division tags: result sign, degenerate flag, base coordinate
	always_comb begin
		tag_x.neg  = f_data.nx_neg ^ f_data.side.d_neg;
		tag_x.deg  = f_data.side.deg;
		tag_x.base = f_data.side.bx;
		tag_y.neg  = f_data.ny_neg ^ f_data.side.d_neg;
		tag_y.deg  = f_data.side.deg;
		tag_y.base = f_data.side.by;
	end

	pcp_div u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (f_valid),
		.num_abs  (f_data.nx_abs),
		.den_abs  (f_data.side.d_abs),
		.tag_in   (tag_x),
		.out_valid(vq_x),
		.quo      (q_x),
		.tag_out  (tq_x)
	);

	pcp_div u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (f_valid),
		.num_abs  (f_data.ny_abs),
		.den_abs  (f_data.side.d_abs),
		.tag_in   (tag_y),
		.out_valid(vq_y),
		.quo      (q_y),
		.tag_out  (tq_y)
	);

	// Offset added to the base point and clipped; returns {clipped, value}
	function automatic logic [CW:0] finish(input tag_t t, input logic [QB:0] q);
		logic [VW-1:0]        mu;
		logic signed [VW-1:0] b;
		logic signed [VW-1:0] v;
		logic                 hi_o;
		logic                 lo_o;
		logic [CW-1:0]        c;
		mu   = q[QB] ? (VW'(1) << QB) : VW'(q[QB-1:0]);
		b    = VW'(t.base);
		v    = t.neg ? b - $signed(mu) : b + $signed(mu);
		hi_o = (v > VHI);
		lo_o = (v < VLO);
		c    = hi_o ? CW'(VHI) : (lo_o ? CW'(VLO) : CW'(v));
		return {hi_o | lo_o, c};
	endfunction

	logic [CW:0] fx, fy;
	logic        deg;
	res_t        r_next;

	always_comb begin
		fx  = finish(tq_x, q_x);
		fy  = finish(tq_y, q_y);
		deg = tq_x.deg | tq_y.deg;
		if (deg) begin
			r_next.center_x   = '0;
			r_next.center_y   = '0;
			r_next.degenerate = 1'b1;
			r_next.saturated  = 1'b0;
		end else begin
			r_next.center_x   = fx[CW-1:0];
			r_next.center_y   = fy[CW-1:0];
			r_next.degenerate = 1'b0;
			r_next.saturated  = fx[CW] | fy[CW];
		end
	end

	// Output stage and skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sout   <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (en) v_sout <= vq_x & vq_y;
			if (!skid_v_q) begin
				if (v_sout && !res.ready) skid_v_q <= 1'b1;
			end else if (res.ready) begin
				skid_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) res_sout <= r_next;
		if (!skid_v_q) skid_q <= res_sout;
	end

	assign res.valid      = skid_v_q | v_sout;
	assign res.center_x   = skid_v_q ? skid_q.center_x : res_sout.center_x;
	assign res.center_y   = skid_v_q ? skid_q.center_y : res_sout.center_y;
	assign res.degenerate = skid_v_q ? skid_q.degenerate : res_sout.degenerate;
	assign res.saturated  = skid_v_q ? skid_q.saturated : res_sout.saturated;

endmodule

### tb/sv/tb_power_center_of_three_points_unit.sv
`timescale 1ns / 1ps
// Testbench for power_center_of_three_points_unit: random and directed point triples,
// checked against an exact wide-integer predictor. Depends on pcp_pkg and both channel interfaces.

module tb_power_center_of_three_points_unit import pcp_pkg::*; ();

	localparam int LAT = 47;

	logic clk;
	logic arst_n;

	pcp_in_if  pts ();
	pcp_out_if res ();

	power_center_of_three_points_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pts    (pts.sink),
		.res    (res.source)
	);

	res_t centers_due[$];
	int   n_bad;
	int   send_idle_pct;
	int   recv_idle_pct;

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Round num/(2*den) ties away from zero, add base, clip to coordinate range
	function automatic coord_t clip_center(logic signed [255:0] num, logic signed [255:0] den,
			coord_t base, inout logic sat);
		logic signed [255:0] an, ad, q, v;
		logic                neg;
		neg = (num < 0) != (den < 0);
		an  = (num < 0) ? -num : num;
		ad  = (den < 0) ? -den : den;
		q   = (an + ad) / (2 * ad);
		v   = neg ? base - q : base + q;
		if (v > 256'sd2147483647) begin
			v   = 256'sd2147483647;
			sat = 1'b1;
		end
		if (v < -256'sd2147483648) begin
			v   = -256'sd2147483648;
			sat = 1'b1;
		end
		return coord_t'(v);
	endfunction

	// Power center of three weighted points
	function automatic res_t power_center(pts_t p);
		logic signed [255:0] dx2, dy2, dw2, dx3, dy3, dw3, den, n2, n3;
		res_t r;
		logic sat;
		dx2 = p.p2_x - p.p1_x;
		dy2 = p.p2_y - p.p1_y;
		dw2 = p.p2_w - p.p1_w;
		dx3 = p.p3_x - p.p1_x;
		dy3 = p.p3_y - p.p1_y;
		dw3 = p.p3_w - p.p1_w;
		sat = 1'b0;
		den = dx2 * dy3 - dx3 * dy2;
		if (den == 0) begin
			r = '{center_x: '0, center_y: '0, degenerate: 1'b1, saturated: 1'b0};
			return r;
		end
		n2 = dx2 * dx2 + dy2 * dy2 + (dw2 <<< FB);
		n3 = dx3 * dx3 + dy3 * dy3 + (dw3 <<< FB);
		r.center_x   = clip_center(n2 * dy3 - n3 * dy2, den, p.p1_x, sat);
		r.center_y   = clip_center(dx2 * n3 - dx3 * n2, den, p.p1_y, sat);
		r.degenerate = 1'b0;
		r.saturated  = sat;
		return r;
	endfunction

	// Drive one triple until its transfer; valid stays up for a following item
	task automatic send_points(pts_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			pts.valid <= 1'b0;
			@(negedge clk);
		end
		pts.valid <= 1'b1;
		{pts.p1_x, pts.p1_y, pts.p1_w, pts.p2_x, pts.p2_y, pts.p2_w,
			pts.p3_x, pts.p3_y, pts.p3_w} <= p;
		centers_due.insert(centers_due.size(), power_center(p));
		@(posedge clk);
		while (!pts.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Receiver stalls
	always @(negedge clk) res.ready <= ($urandom_range(99) >= recv_idle_pct);

	// Result checker
	always @(posedge clk) begin
		res_t got, want;
		if (arst_n && res.valid && res.ready) begin
			got = '{res.center_x, res.center_y, res.degenerate, res.saturated};
			if (centers_due.size() == 0) begin
				n_bad++;
				if (n_bad <= 10) $display("unexpected result %p", got);
			end else begin
				want = centers_due.pop_front();
				if (got !== want) begin
					n_bad++;
					if (n_bad <= 10) $display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	function automatic coord_t rnd_coord();
		case ($urandom_range(3))
			0: return coord_t'($urandom);
			1: return coord_t'($signed($urandom_range(65535)) - 32768) <<< 8;
			2: return $urandom_range(1) ? 32'sh7fffffff - $urandom_range(3)
				: 32'sh80000000 + $urandom_range(3);
			default: return coord_t'($signed($urandom_range(2047)) - 1024);
		endcase
	endfunction

	function automatic pts_t rnd_points();
		pts_t p;
		p = {rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
			rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
		return p;
	endfunction

	// Extremes, coincident, collinear, small triangles, weights
	task automatic test_directed();
		coord_t mx, mn;
		mx = 32'sh7fffffff;
		mn = 32'sh80000000;
		send_points('0);
		send_points({mx, mx, mx, mx, mx, mx, mx, mx, mx});
		send_points({32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0,
			32'sd0, 32'sd65536, 32'sd0});
		send_points({32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd65536,
			32'sd0, 32'sd65536, -32'sd65536});
		send_points({32'sd5, 32'sd5, 32'sd0, 32'sd5, 32'sd5, 32'sd9,
			32'sd7, 32'sd1, 32'sd0});
		send_points({32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd1, 32'sd0,
			32'sd2, 32'sd2, 32'sd0});
		send_points({mn, mn, mn, mx, mn, mx, mn, mx, mn});
		send_points({mx, mx, mn, mn, mx, mx, mx, mn, mx});
		send_points({mn, mn, mx, mn, mn, mn, mx, mx, mx});
		send_points({32'sd0, 32'sd0, mx, 32'sd1, 32'sd0, mn, 32'sd0, 32'sd1, mn});
		send_points({32'sd0, 32'sd0, mn, 32'sd1, 32'sd0, mx, 32'sd0, 32'sd1, mx});
		send_points({32'sd0, 32'sd0, 32'sd0, 32'sd3, 32'sd0, 32'sd0,
			32'sd0, 32'sd4, 32'sd0});
		send_points({-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1,
			-32'sd1, -32'sd1, -32'sd1});
		send_points({32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0,
			32'sd0, 32'sd1, 32'sd0});
		send_points({32'sd0, 32'sd0, 32'sd0, -32'sd1, 32'sd0, 32'sd0,
			32'sd0, 32'sd1, 32'sd0});
	endtask

	// Random triples under one idling pattern; some collinear
	task automatic test_random(int n);
		pts_t p;
		int k;
		repeat (n) begin
			p = rnd_points();
			if ($urandom_range(9) == 0) begin
				k = $signed($urandom_range(6)) - 3;
				p.p3_x = p.p1_x + k * (p.p2_x - p.p1_x);
				p.p3_y = p.p1_y + k * (p.p2_y - p.p1_y);
			end
			send_points(p);
		end
	endtask

	// Stimulus sequence
	initial begin
		n_bad         = 0;
		send_idle_pct = 9;
		recv_idle_pct = 74;
		arst_n        = 1'b0;
		pts.valid     = 1'b0;
		{pts.p1_x, pts.p1_y, pts.p1_w, pts.p2_x, pts.p2_y, pts.p2_w,
			pts.p3_x, pts.p3_y, pts.p3_w} = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(170);
		send_idle_pct = 74;
		recv_idle_pct = 9;
		test_random(180);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(180);
		pts.valid <= 1'b0;
		while (centers_due.size() != 0) @(posedge clk);
		repeat (LAT + 10) @(posedge clk);
		if (n_bad == 0)
			$display("** power_center_of_three_points_unit: PASSED **");
		else
			$display("** power_center_of_three_points_unit: FAILED **");
		$finish;
	end

	// Timeout
	initial begin
		#2000000;
		$display("** power_center_of_three_points_unit: FAILED **");
		$finish;
	end

endmodule

### sim.f
src/pcp_pkg.sv
src/pcp_in_if.sv
src/pcp_out_if.sv
src/pcp_front.sv
src/pcp_div.sv
src/power_center_of_three_points_unit.sv
tb/sv/tb_power_center_of_three_points_unit.sv
